// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: defaults, field widths, command,
// status and sequencer codes.
// No dependencies; compile first.
package cdq_pkg;

  localparam int unsigned DepthDef     = 8;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_REAR   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// ----- rtl/cdq_if.sv -----
// Valid/ready channel interfaces of the circular deque: command channel
// and response channel.
// Depends on cdq_pkg.
interface cdq_cmd_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic signed [ValueW-1:0] value_in;

  modport source (output valid, output command, output value_in, input ready);
  modport sink   (input valid, input command, input value_in, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value_out;
  logic [StatW-1:0]         status;

  modport source (output valid, output value_out, output status, input ready);
  modport sink   (input valid, input value_out, input status, output ready);
endinterface

// ----- rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/circular_deque_top.sv -----
// Circular deque: DEPTH-entry ring in a RAM, front/rear indices, empty flag.
// Responses: an insert or refused command answers from the result register;
// a removal reads the RAM, then loads the result register, and no new command
// is taken meanwhile. Throughput: one insert per cycle unless responses stall.
// Reset: indices to zero, deque empty, output idle; RAM contents not cleared.
// Depends on cdq_pkg, cdq_if, cdq_ram.
module circular_deque_top #(
  parameter int unsigned DEPTH      = cdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DataWidthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cdq_cmd_if.sink   cmd_i,
  cdq_rsp_if.source rsp_o
);
  import cdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [IdxW-1:0] IdxZero = '0;

  state_e          state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] rear_q, rear_d;
  logic            empty_q, empty_d;
  logic            out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_val_q, out_val_d;
  status_e         out_stat_q, out_stat_d;

  logic                  accept;
  cmd_e                  cmd;
  logic                  full;
  logic [IdxW-1:0]       rear_next, rear_prev, front_next, front_prev;
  logic                  ram_we, ram_re;
  logic [IdxW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [ValueW-1:0]     rd_val;

  assign cmd = cmd_e'(cmd_i.command);

  // Fit the 32-bit value to the stored width and back.
  generate
    if (DATA_WIDTH <= ValueW) begin : g_narrow
      assign ram_wdata = cmd_i.value_in[DATA_WIDTH-1:0];
      if (DATA_WIDTH == ValueW) begin : g_same
        assign rd_val = ram_rdata;
      end else begin : g_pad
        assign rd_val = {{(ValueW-DATA_WIDTH){1'b0}}, ram_rdata};
      end
    end else begin : g_wide
      assign ram_wdata = {{(DATA_WIDTH-ValueW){cmd_i.value_in[ValueW-1]}}, cmd_i.value_in};
      assign rd_val    = ram_rdata[ValueW-1:0];
    end
  endgenerate

  assign rear_next  = (rear_q == IdxLast)  ? IdxZero : rear_q + 1'b1;
  assign rear_prev  = (rear_q == IdxZero)  ? IdxLast : rear_q - 1'b1;
  assign front_next = (front_q == IdxLast) ? IdxZero : front_q + 1'b1;
  assign front_prev = (front_q == IdxZero) ? IdxLast : front_q - 1'b1;
  assign full       = !empty_q && (rear_next == front_q);

  // Take an item only when the result register is free by the time it loads.
  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !empty_q &&
            (cmd == CMD_POP_REAR || cmd == CMD_POP_FRONT)) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Index update, RAM access and result register.
  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    ram_we      = 1'b0;
    ram_waddr   = IdxZero;
    ram_re      = 1'b0;
    ram_raddr   = IdxZero;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_val_d   = out_val_q;
    out_stat_d  = out_stat_q;

    if (state_q == S_READ) begin
      out_valid_d = 1'b1;
      out_val_d   = rd_val;
      out_stat_d  = ST_DONE;
    end else if (accept) begin
      unique case (cmd)
        CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
          out_valid_d = 1'b1;
          out_val_d   = '0;
          if (full) begin
            out_stat_d = ST_FULL;
          end else begin
            out_stat_d = ST_DONE;
            ram_we     = 1'b1;
            if (empty_q) begin
              front_d   = IdxZero;
              rear_d    = IdxZero;
              empty_d   = 1'b0;
              ram_waddr = IdxZero;
            end else if (cmd == CMD_PUSH_REAR) begin
              rear_d    = rear_next;
              ram_waddr = rear_next;
            end else begin
              front_d   = front_prev;
              ram_waddr = front_prev;
            end
          end
        end
        CMD_POP_REAR, CMD_POP_FRONT: begin
          if (empty_q) begin
            out_valid_d = 1'b1;
            out_val_d   = '0;
            out_stat_d  = ST_EMPTY;
          end else begin
            // Read now and answer from the read state; indices move right away.
            ram_re    = 1'b1;
            ram_raddr = (cmd == CMD_POP_REAR) ? rear_q : front_q;
            if (front_q == rear_q) begin
              front_d = IdxZero;
              rear_d  = IdxZero;
              empty_d = 1'b1;
            end else if (cmd == CMD_POP_REAR) begin
              rear_d = rear_prev;
            end else begin
              front_d = front_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value_out = out_val_q;
  assign rsp_o.status    = out_stat_q;

  // The result register must be free while a read is in flight.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !out_valid_q)
    else $error("result register busy during RAM read");

  // An empty deque keeps both indices at zero.
  a_empty_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (front_q == IdxZero && rear_q == IdxZero))
    else $error("empty deque with nonzero index");

  // Indices stay inside the ring.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= IdxLast && rear_q <= IdxLast)
    else $error("deque index out of range");

  // A removal from a non-empty deque answers with done after the read.
  a_pop_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> (out_valid_q && out_stat_q == ST_DONE))
    else $error("removal result not loaded after read");

  // No write while a read is pending.
  a_no_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !ram_we)
    else $error("RAM write during pending read");

endmodule

// ----- tb/circular_deque_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for circular_deque_top: drives insert and remove commands and checks each
// response against a shadow deque kept in the bench.
// Depends on cdq_pkg, cdq_if, circular_deque_top.
module circular_deque_top_test;
  import cdq_pkg::*;

  localparam int unsigned RingDepth     = DepthDef;
  localparam int unsigned IdlePct       = 17;
  localparam int unsigned RandomItems   = 1300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 6;

  typedef struct {
    cmd_e                     cmd;
    logic signed [ValueW-1:0] value;
    bit                       burst;
  } deque_cmd_t;

  typedef struct {
    logic signed [ValueW-1:0] value;
    status_e                  status;
  } deque_resp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cdq_cmd_if cmd_if ();
  cdq_rsp_if rsp_if ();

  circular_deque_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  deque_cmd_t  pending_cmd_q[$];
  deque_resp_t resp_expect_q[$];

  // Shadow of the deque contents and indices.
  logic signed [ValueW-1:0] shadow_ring[RingDepth];
  int unsigned front_idx = 0;
  int unsigned rear_idx  = 0;
  bit          ring_empty = 1'b1;

  int unsigned err_count   = 0;
  int unsigned n_insert_ok = 0;
  int unsigned n_remove_ok = 0;
  int unsigned n_full      = 0;
  int unsigned n_empty     = 0;
  int unsigned idle_cycles = 0;
  bit          burst_mode  = 1'b0;

  function automatic int unsigned idx_inc(int unsigned i);
    return (i == RingDepth - 1) ? 0 : i + 1;
  endfunction

  function automatic int unsigned idx_dec(int unsigned i);
    return (i == 0) ? RingDepth - 1 : i - 1;
  endfunction

  // Apply one command to the shadow deque and return the response it must produce.
  function automatic deque_resp_t deque_step(cmd_e cmd, logic signed [ValueW-1:0] value);
    deque_resp_t r;
    int unsigned slot;
    r.value  = '0;
    r.status = ST_DONE;
    if (cmd == CMD_PUSH_REAR || cmd == CMD_PUSH_FRONT) begin
      if (!ring_empty && idx_inc(rear_idx) == front_idx) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        if (ring_empty) begin
          front_idx  = 0;
          rear_idx   = 0;
          ring_empty = 1'b0;
          slot       = 0;
        end else if (cmd == CMD_PUSH_REAR) begin
          rear_idx = idx_inc(rear_idx);
          slot     = rear_idx;
        end else begin
          front_idx = idx_dec(front_idx);
          slot      = front_idx;
        end
        shadow_ring[slot] = value;
        n_insert_ok++;
      end
    end else begin
      if (ring_empty) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        slot    = (cmd == CMD_POP_REAR) ? rear_idx : front_idx;
        r.value = shadow_ring[slot];
        if (front_idx == rear_idx) begin
          front_idx  = 0;
          rear_idx   = 0;
          ring_empty = 1'b1;
        end else if (cmd == CMD_POP_REAR) begin
          rear_idx = idx_dec(rear_idx);
        end else begin
          front_idx = idx_inc(front_idx);
        end
        n_remove_ok++;
      end
    end
    return r;
  endfunction

  initial begin
    cmd_if.valid    = 1'b0;
    cmd_if.command  = '0;
    cmd_if.value_in = '0;
    rsp_if.ready    = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Command driver: predict on accept, then present the next item or idle.
  always @(posedge clk_i) begin : drive_cmd
    deque_cmd_t nxt;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        resp_expect_q.push_back(deque_step(cmd_e'(cmd_if.command), cmd_if.value_in));
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmd_q.size() > 0 &&
            (pending_cmd_q[0].burst || $urandom_range(99) >= IdlePct)) begin
          nxt = pending_cmd_q.pop_front();
          burst_mode = nxt.burst;
          cmd_if.valid    <= 1'b1;
          cmd_if.command  <= nxt.cmd;
          cmd_if.value_in <= nxt.value;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check against the oldest expectation, stall at random.
  always @(posedge clk_i) begin : watch_rsp
    deque_resp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (resp_expect_q.size() == 0) begin
          $error("unexpected response: value_out %h status %0d",
                 rsp_if.value_out, rsp_if.status);
          err_count++;
        end else begin
          want = resp_expect_q.pop_front();
          if (rsp_if.value_out !== want.value) begin
            $error("value_out mismatch: expected %h, actual %h", want.value, rsp_if.value_out);
            err_count++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
            err_count++;
          end
        end
      end
      rsp_if.ready <= burst_mode || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("circular_deque_top_test: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_cmd(cmd_e cmd, logic signed [ValueW-1:0] value, bit burst = 1'b0);
    deque_cmd_t item;
    item.cmd   = cmd;
    item.value = value;
    item.burst = burst;
    pending_cmd_q.push_back(item);
  endtask

  // Hold until every queued item is accepted and answered; look at the falling
  // edge so the driver's updates from the rising edge have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmd_q.size() != 0 || cmd_if.valid || resp_expect_q.size() != 0);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 32'sh7fff_ffff;
      3:       return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned made;
    int unsigned seg_len;
    int unsigned bias;
    int unsigned roll;
    bit          do_insert;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Removals from empty, single-entry insert/remove from either end.
    queue_cmd(CMD_POP_REAR, 32'sh1234_5678);
    queue_cmd(CMD_POP_FRONT, '1);
    queue_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    queue_cmd(CMD_POP_REAR, '0);
    queue_cmd(CMD_PUSH_REAR, 32'sh8000_0000);
    queue_cmd(CMD_POP_FRONT, '0);
    // Fill to capacity from both ends so the front index wraps.
    queue_cmd(CMD_PUSH_REAR, '1);
    queue_cmd(CMD_PUSH_FRONT, '0);
    queue_cmd(CMD_PUSH_FRONT, 32'sh5555_5555);
    queue_cmd(CMD_PUSH_REAR, 32'shaaaa_aaaa);
    queue_cmd(CMD_PUSH_FRONT, 32'sh0000_0001);
    queue_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
    queue_cmd(CMD_PUSH_REAR, 32'shdead_beef);
    // Inserts into a full deque are refused.
    queue_cmd(CMD_PUSH_REAR, 32'sh0bad_0bad);
    queue_cmd(CMD_PUSH_FRONT, 32'sh0bad_0bad);
    repeat (4) queue_cmd(CMD_POP_FRONT, '0);
    repeat (4) queue_cmd(CMD_POP_REAR, '1);
    queue_cmd(CMD_POP_FRONT, '0);
    wait_drained();

    // Random segments that lean toward filling, draining or neither.
    made = 0;
    while (made < RandomItems) begin
      seg_len = $urandom_range(30, 5);
      bias    = $urandom_range(2);
      for (int unsigned k = 0; k < seg_len && made < RandomItems; k++) begin
        roll      = $urandom_range(99);
        do_insert = (bias == 0) ? (roll < 80) : (bias == 1) ? (roll < 20) : (roll < 50);
        if (do_insert) begin
          queue_cmd($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_value(),
                    made >= 500 && made < 800);
        end else begin
          queue_cmd($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_value(),
                    made >= 500 && made < 800);
        end
        made++;
        if (made == 300 || made == 900) wait_drained();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d inserts and %0d removals, %0d refused as full, %0d as empty",
             n_insert_ok, n_remove_ok, n_full, n_empty);
    if (err_count == 0) begin
      $display("circular_deque_top_test: done, clean");
    end else begin
      $display("circular_deque_top_test: done, errors");
    end
    $finish;
  end

endmodule
